// ----- rtl/pkm_pkg.sv -----
// shared types, keyword table and helpers for the priority keyword matcher
package pkm_pkg;

	// table geometry of the keyword rom
	localparam int TABLE_SLOTS = 64;
	localparam int TEXT_SLOTS  = 16;
	localparam int TEXT_BITS   = TEXT_SLOTS * 8;

	// category reported when no keyword occurred
	localparam logic [3:0] CATEGORY_NONE = 4'd15;

	// input transaction
	typedef struct packed {
		logic [7:0] screen_code;
		logic       char_present;
		logic       last_char;
	} pkm_in_t;

	// output transaction
	typedef struct packed {
		logic [3:0] category;
		logic       any_match;
	} pkm_out_t;

	// keyword text, right-justified ascii: byte 0 holds the final letter
	localparam logic [TEXT_BITS-1:0] KW_TEXT [TABLE_SLOTS] = '{
		0:  TEXT_BITS'("HEALTH"),    1:  TEXT_BITS'("PEACE"),
		2:  TEXT_BITS'("QUIET"),     3:  TEXT_BITS'("HARMONY"),
		4:  TEXT_BITS'("FREEDOM"),   5:  TEXT_BITS'("FREE"),
		6:  TEXT_BITS'("CONNECT"),   7:  TEXT_BITS'("LEARN"),
		8:  TEXT_BITS'("KNOWLEDGE"), 9:  TEXT_BITS'("EDUCATION"),
		10: TEXT_BITS'("CREATE"),    11: TEXT_BITS'("ART"),
		12: TEXT_BITS'("MUSIC"),     13: TEXT_BITS'("WRITE"),
		14: TEXT_BITS'("EQUAL"),     15: TEXT_BITS'("FAIR"),
		16: TEXT_BITS'("SAFE"),      17: TEXT_BITS'("SECURITY"),
		18: TEXT_BITS'("PROTECT"),   19: TEXT_BITS'("TRUTH"),
		20: TEXT_BITS'("HONEST"),    21: TEXT_BITS'("TRUST"),
		22: TEXT_BITS'("HUMAN"),     23: TEXT_BITS'("PEOPLE"),
		24: TEXT_BITS'("BETTER"),    25: TEXT_BITS'("IMPROVE"),
		26: TEXT_BITS'("PROGRESS"),  27: TEXT_BITS'("FUTURE"),
		28: TEXT_BITS'("HOPE"),      29: TEXT_BITS'("TOMORROW"),
		30: TEXT_BITS'("WORK"),      31: TEXT_BITS'("JOB"),
		32: TEXT_BITS'("EARN"),      33: TEXT_BITS'("LOVE"),
		34: TEXT_BITS'("FAMILY"),    35: TEXT_BITS'("TOGETHER"),
		36: TEXT_BITS'("THINK"),     37: TEXT_BITS'("MIND"),
		38: TEXT_BITS'("IDEA"),
		default: '0
	};

	// category of each keyword; empty slots never match
	localparam logic [3:0] KW_CAT [TABLE_SLOTS] = '{
		0: 4'd0,   1: 4'd1,   2: 4'd1,   3: 4'd1,   4: 4'd2,   5: 4'd2,
		6: 4'd3,   7: 4'd4,   8: 4'd4,   9: 4'd4,   10: 4'd5,  11: 4'd5,
		12: 4'd5,  13: 4'd5,  14: 4'd6,  15: 4'd6,  16: 4'd7,  17: 4'd7,
		18: 4'd7,  19: 4'd8,  20: 4'd8,  21: 4'd8,  22: 4'd9,  23: 4'd9,
		24: 4'd10, 25: 4'd10, 26: 4'd10, 27: 4'd11, 28: 4'd11, 29: 4'd11,
		30: 4'd12, 31: 4'd12, 32: 4'd12, 33: 4'd13, 34: 4'd13, 35: 4'd13,
		36: 4'd14, 37: 4'd14, 38: 4'd14,
		default: 4'd0
	};

	// number of letters in a keyword slot
	function automatic logic [4:0] kw_len(input int slot);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < TEXT_SLOTS; i++) begin
			if (KW_TEXT[slot][8*i +: 8] != 8'd0) begin
				n = 5'(i + 1);
			end
		end
		return n;
	endfunction

	// ascii letter to screen code, anything else to zero
	function automatic logic [7:0] letter_code(input logic [7:0] ascii);
		logic [7:0] code;
		code = 8'd0;
		if (ascii >= 8'h41 && ascii <= 8'h5A) begin
			code = ascii - 8'h40;
		end
		return code;
	endfunction

endpackage

// ----- rtl/priority_keyword_matcher.sv -----
// top level: input register, window and found state, result register
//
//  channel | direction | payload            | handshake
//  in      | into      | pkm_in_t  in_data  | in_valid / in_ready
//  out     | out of    | pkm_out_t out_data | out_valid / out_ready
//
// one input transaction per cycle unless a last item waits on a stalled result;
// a result follows its last item through the input register, then the result register
// the compare of all keywords and the priority pick sit between those two registers
// reset clears the window, the found bits and both valid flags at once
// a waiting result stalls only a last item held in the input register

module priority_keyword_matcher
	import pkm_pkg::*;
#(
	parameter int KEYWORD_COUNT   = 39,
	parameter int MAX_KEYWORD_LEN = 9
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pkm_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output pkm_out_t out_data
);

	logic                     valid_s1;
	pkm_in_t                  item_s1;
	logic                     out_free;
	logic                     advance;
	logic [7:0]               hist [MAX_KEYWORD_LEN];
	logic [KEYWORD_COUNT-1:0] hits;
	logic [KEYWORD_COUNT-1:0] found_q;
	logic [KEYWORD_COUNT-1:0] found_now;
	pkm_out_t                 result;

	// flow control
	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (!item_s1.last_char || out_free);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// window of recent characters plus the current one
	assign hist[0] = item_s1.screen_code;

	if (MAX_KEYWORD_LEN > 1) begin : g_win
		localparam int DEPTH = MAX_KEYWORD_LEN - 1;
		logic [7:0] recent_q [DEPTH];

		for (genvar k = 1; k < MAX_KEYWORD_LEN; k++) begin : g_tap
			assign hist[k] = recent_q[k-1];
		end

		// shift on a present character, clear at end of string
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < DEPTH; k++) begin
					recent_q[k] <= 8'd0;
				end
			end else if (advance) begin
				if (item_s1.last_char) begin
					for (int k = 0; k < DEPTH; k++) begin
						recent_q[k] <= 8'd0;
					end
				end else if (item_s1.char_present) begin
					for (int k = 0; k < DEPTH; k++) begin
						recent_q[k] <= hist[k];
					end
				end
			end
		end
	end

	pkm_match #(
		.KEYWORD_COUNT  (KEYWORD_COUNT),
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_match (
		.hist(hist),
		.hits(hits)
	);

	// found bits including this character's hits
	assign found_now = found_q | (item_s1.char_present ? hits : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (advance) begin
			found_q <= item_s1.last_char ? '0 : found_now;
		end
	end

	pkm_prio #(
		.KEYWORD_COUNT(KEYWORD_COUNT)
	) u_prio (
		.found (found_now),
		.result(result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && item_s1.last_char) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_char) begin
			out_data <= result;
		end
	end

endmodule

// ----- rtl/pkm_match.sv -----
// parallel compare of the character window against every keyword
module pkm_match
	import pkm_pkg::*;
#(
	parameter int KEYWORD_COUNT   = 39,
	parameter int MAX_KEYWORD_LEN = 9
) (
	input  logic [7:0]               hist [MAX_KEYWORD_LEN],
	output logic [KEYWORD_COUNT-1:0] hits
);

	// one comparator per keyword slot, each ending at the current character
	for (genvar t = 0; t < KEYWORD_COUNT; t++) begin : g_kw
		localparam int LEN = int'(kw_len(t));
		if (LEN >= 1 && LEN <= MAX_KEYWORD_LEN) begin : g_live
			logic [LEN-1:0] eq;
			for (genvar i = 0; i < LEN; i++) begin : g_chr
				assign eq[i] = (hist[i] == letter_code(KW_TEXT[t][8*i +: 8]));
			end
			assign hits[t] = &eq;
		end else begin : g_dead
			// empty slot or keyword longer than the window
			assign hits[t] = 1'b0;
		end
	end

endmodule

// ----- rtl/pkm_prio.sv -----
// lowest-numbered found keyword to category
module pkm_prio
	import pkm_pkg::*;
#(
	parameter int KEYWORD_COUNT = 39
) (
	input  logic [KEYWORD_COUNT-1:0] found,
	output pkm_out_t                 result
);

	// scan from the top so the lowest set bit wins
	always_comb begin
		result.category  = CATEGORY_NONE;
		result.any_match = |found;
		for (int t = KEYWORD_COUNT - 1; t >= 0; t--) begin
			if (found[t]) begin
				result.category = KW_CAT[t];
			end
		end
	end

endmodule

// ----- rtl/pkm_checker.sv -----
// port-level checks for the priority keyword matcher, bound to the top level
module pkm_port_checks
	import pkm_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input pkm_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input pkm_out_t out_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// no result once reset has been seen at an edge
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid in reset");

	// with the result slot empty nothing blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	// a last item behind a stalled result must block further input
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.last_char && out_valid && !out_ready)
		##1 (out_valid && !out_ready) |-> !in_ready)
		else $error("input taken past a blocked end of string");

	// category none goes with no match and only with it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.any_match != (out_data.category == CATEGORY_NONE)))
		else $error("category and match flag disagree");

endmodule

bind priority_keyword_matcher pkm_port_checks u_pkm_port_checks (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
